// File: hw/rtl/rtr_pkg.sv
// Shared types, constants and helpers of the reliable transfer receiver.
package rtr_pkg;

  // Field widths fixed by the packet header format
  localparam int unsigned SEQ_W  = 15;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned CNT_W  = 4;

  // Sequence space is 0..25600
  localparam logic [15:0] SeqMod = 16'd25601;

  // Results one request may cause
  localparam logic [CNT_W-1:0] MaxResults = 4'd10;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_INIT_SEQ = 1'b0;
  localparam logic [SEQ_W-1:0] InitSeqReset = 15'd7706;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_HANDSHAKE = 2'd1,
    PH_CONNECTED = 2'd2,
    PH_CLOSING   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_STORE   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_DISPATCH,
    ST_SYNACK,
    ST_FINACK,
    ST_FIN,
    ST_DELIVER,
    ST_MATCH,
    ST_PICK,
    ST_STORE,
    ST_ACK
  } back_state_e;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic              syn;
    logic              fin;
    logic              ack_ok;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  seq_p1;
    logic [SIZE_W-1:0] size;
  } item_t;

  // One result item
  typedef struct packed {
    kind_e             kind;
    logic              ack_bit;
    logic              syn_bit;
    logic              fin_bit;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic              from_buffer;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  dseq;
    logic [SIZE_W-1:0] dsize;
    logic              last;
  } result_t;

  // Reduce a value below twice the modulus into the sequence space
  function automatic logic [SEQ_W-1:0] seq_wrap(input logic [15:0] v);
    logic [15:0] r;
    r = (v >= SeqMod) ? (v - SeqMod) : v;
    return r[SEQ_W-1:0];
  endfunction

endpackage

// File: hw/rtl/rtr_front.sv
// Front end: accept a header request, classify it and hand it to the queue.
module rtr_front #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        syn_i,
  input  logic                        fin_i,
  input  logic [rtr_pkg::SEQ_W-1:0]   seq_i,
  input  logic [rtr_pkg::SEQ_W-1:0]   ack_i,
  input  logic [rtr_pkg::SIZE_W-1:0]  size_i,
  input  logic [rtr_pkg::SEQ_W-1:0]   hs_ack_i,
  output rtr_pkg::item_t              item_o,
  output logic                        item_valid_o,
  input  logic                        item_ready_i
);

  localparam logic [12:0] MaxPay = 13'(MAX_PAYLOAD);

  logic           valid_q, valid_d;
  rtr_pkg::item_t item_q, item_c;
  logic           accept;

  // Classify: saturate the size, precompute seq+1 and the handshake check
  always_comb begin
    item_c.syn    = syn_i;
    item_c.fin    = fin_i;
    item_c.ack_ok = (ack_i == hs_ack_i);
    item_c.seq    = seq_i;
    item_c.seq_p1 = rtr_pkg::seq_wrap({1'b0, seq_i} + 16'd1);
    item_c.size   = ({3'b000, size_i} > MaxPay) ? MaxPay[rtr_pkg::SIZE_W-1:0] : size_i;
  end

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Hold the request until the queue takes it
  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_c;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

// File: hw/rtl/rtr_fifo.sv
// Short queue of classified requests between front and back.
module rtr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rtr_pkg::item_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output rtr_pkg::item_t data_o,
  output logic           valid_o
);

  localparam int unsigned Depth = rtr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  rtr_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign ready_o = (cnt_q != DepthC);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/rtr_back.sv
// Back end: connection phase, reassembly slots and result sequencing.
module rtr_back #(
  parameter int unsigned BUFFER_SLOTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rtr_pkg::item_t            item_i,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  logic [rtr_pkg::SEQ_W-1:0] init_seq_i,
  output rtr_pkg::result_t          res_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i
);

  localparam int unsigned SlotW = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam int unsigned SW    = rtr_pkg::SEQ_W;
  localparam int unsigned ZW    = rtr_pkg::SIZE_W;

  rtr_pkg::back_state_e state_q, state_d;
  rtr_pkg::phase_e      phase_q, phase_d;
  logic [SW-1:0]        exp_q, exp_d;
  logic [BUFFER_SLOTS-1:0] valid_q, valid_d;
  logic [rtr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [BUFFER_SLOTS-1:0] match_q, match_d, match_vec;
  rtr_pkg::item_t       cur_q, cur_d;
  logic [SW-1:0]        slot_seq_q  [BUFFER_SLOTS];
  logic [ZW-1:0]        slot_size_q [BUFFER_SLOTS];
  logic                 out_valid_q, out_valid_d;
  rtr_pkg::result_t     res_q, res_d, res_new;

  logic             emit, emit_ok;
  logic             slot_wr;
  logic [SlotW-1:0] pick_idx, free_idx;
  logic             pick_any, free_any;
  logic [SW-1:0]    pick_seq, exp_cur, exp_pick;
  logic [ZW-1:0]    pick_size;
  logic             in_order;
  logic [31:0]      pick_wide, free_wide;

  assign emit_ok = !out_valid_q || res_ready_i;

  // Compare every held slot against the expected sequence number
  always_comb begin
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      match_vec[i] = valid_q[i] && (slot_seq_q[i] == exp_q);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    pick_idx = '0;
    free_idx = '0;
    for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        pick_idx = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  assign pick_any  = |match_q;
  assign free_any  = ~&valid_q;
  assign pick_seq  = slot_seq_q[pick_idx];
  assign pick_size = slot_size_q[pick_idx];
  assign pick_wide = 32'(pick_idx);
  assign free_wide = 32'(free_idx);
  assign in_order  = (cur_q.seq == exp_q);
  assign exp_cur   = rtr_pkg::seq_wrap({1'b0, exp_q} + 16'(cur_q.size));
  assign exp_pick  = rtr_pkg::seq_wrap({1'b0, exp_q} + 16'(pick_size));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtr_pkg::ST_WAIT: begin
        if (item_valid_i) begin
          state_d = rtr_pkg::ST_DISPATCH;
        end
      end
      rtr_pkg::ST_DISPATCH: begin
        if (phase_q == rtr_pkg::PH_HANDSHAKE || phase_q == rtr_pkg::PH_CLOSING) begin
          state_d = rtr_pkg::ST_WAIT;
        end else if (cur_q.syn) begin
          state_d = rtr_pkg::ST_SYNACK;
        end else if (cur_q.fin) begin
          state_d = rtr_pkg::ST_FINACK;
        end else if (phase_q == rtr_pkg::PH_CONNECTED) begin
          if (!in_order) begin
            state_d = rtr_pkg::ST_STORE;
          end else if (cur_q.size != '0) begin
            state_d = rtr_pkg::ST_DELIVER;
          end else begin
            state_d = rtr_pkg::ST_MATCH;
          end
        end else begin
          state_d = rtr_pkg::ST_WAIT;
        end
      end
      rtr_pkg::ST_SYNACK, rtr_pkg::ST_FIN, rtr_pkg::ST_ACK: begin
        if (emit_ok) begin
          state_d = rtr_pkg::ST_WAIT;
        end
      end
      rtr_pkg::ST_FINACK: begin
        if (emit_ok) begin
          state_d = rtr_pkg::ST_FIN;
        end
      end
      rtr_pkg::ST_DELIVER: begin
        if (emit_ok) begin
          state_d = rtr_pkg::ST_MATCH;
        end
      end
      rtr_pkg::ST_MATCH: begin
        if (cnt_q >= rtr_pkg::MaxResults - 1'b1) begin
          state_d = rtr_pkg::ST_ACK;
        end else begin
          state_d = rtr_pkg::ST_PICK;
        end
      end
      rtr_pkg::ST_PICK: begin
        if (!pick_any) begin
          state_d = rtr_pkg::ST_ACK;
        end else if (pick_size == '0 || emit_ok) begin
          state_d = rtr_pkg::ST_MATCH;
        end
      end
      rtr_pkg::ST_STORE: begin
        if (!free_any || emit_ok) begin
          state_d = rtr_pkg::ST_ACK;
        end
      end
      default: state_d = rtr_pkg::ST_WAIT;
    endcase
  end

  // State updates and result generation
  always_comb begin
    phase_d      = phase_q;
    exp_d        = exp_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    cur_d        = cur_q;
    item_ready_o = 1'b0;
    emit         = 1'b0;
    slot_wr      = 1'b0;
    res_new      = '0;
    res_new.kind = rtr_pkg::KIND_HEADER;
    unique case (state_q)
      rtr_pkg::ST_WAIT: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cur_d = item_i;
        end
      end
      rtr_pkg::ST_DISPATCH: begin
        if (phase_q == rtr_pkg::PH_HANDSHAKE) begin
          if (cur_q.ack_ok) begin
            exp_d   = cur_q.seq_p1;
            phase_d = rtr_pkg::PH_CONNECTED;
          end else begin
            phase_d = rtr_pkg::PH_IDLE;
          end
        end else if (phase_q == rtr_pkg::PH_CLOSING) begin
          phase_d = rtr_pkg::PH_IDLE;
          valid_d = '0;
        end else if (cur_q.syn) begin
          phase_d = rtr_pkg::PH_HANDSHAKE;
        end else if (cur_q.fin) begin
          phase_d = rtr_pkg::PH_CLOSING;
        end else if (phase_q == rtr_pkg::PH_CONNECTED && in_order) begin
          exp_d = exp_cur;
          cnt_d = (cur_q.size != '0) ? rtr_pkg::CNT_W'(1) : '0;
        end
      end
      rtr_pkg::ST_SYNACK: begin
        emit            = emit_ok;
        res_new.ack_bit = 1'b1;
        res_new.syn_bit = 1'b1;
        res_new.seq     = init_seq_i;
        res_new.ack     = cur_q.seq_p1;
        res_new.last    = 1'b1;
      end
      rtr_pkg::ST_FINACK: begin
        emit            = emit_ok;
        res_new.ack_bit = 1'b1;
        res_new.seq     = init_seq_i;
        res_new.ack     = cur_q.seq_p1;
      end
      rtr_pkg::ST_FIN: begin
        emit            = emit_ok;
        res_new.fin_bit = 1'b1;
        res_new.seq     = init_seq_i;
        res_new.last    = 1'b1;
      end
      rtr_pkg::ST_DELIVER: begin
        emit          = emit_ok;
        res_new.kind  = rtr_pkg::KIND_DELIVER;
        res_new.dseq  = cur_q.seq;
        res_new.dsize = cur_q.size;
      end
      rtr_pkg::ST_MATCH: begin
        match_d = match_vec;
      end
      rtr_pkg::ST_PICK: begin
        res_new.kind        = rtr_pkg::KIND_DELIVER;
        res_new.from_buffer = 1'b1;
        res_new.slot        = pick_wide[rtr_pkg::SLOT_W-1:0];
        res_new.dseq        = pick_seq;
        res_new.dsize       = pick_size;
        if (pick_any) begin
          if (pick_size == '0) begin
            valid_d[pick_idx] = 1'b0;
          end else if (emit_ok) begin
            emit              = 1'b1;
            cnt_d             = cnt_q + 1'b1;
            exp_d             = exp_pick;
            valid_d[pick_idx] = 1'b0;
          end
        end
      end
      rtr_pkg::ST_STORE: begin
        res_new.kind  = rtr_pkg::KIND_STORE;
        res_new.slot  = free_wide[rtr_pkg::SLOT_W-1:0];
        res_new.dseq  = cur_q.seq;
        res_new.dsize = cur_q.size;
        if (free_any && emit_ok) begin
          emit              = 1'b1;
          slot_wr           = 1'b1;
          valid_d[free_idx] = 1'b1;
        end
      end
      rtr_pkg::ST_ACK: begin
        emit            = emit_ok;
        res_new.ack_bit = 1'b1;
        res_new.seq     = init_seq_i;
        res_new.ack     = exp_q;
        res_new.last    = 1'b1;
      end
      default: begin
        item_ready_o = 1'b0;
      end
    endcase
  end

  // Output register: load a new result, drop it once taken
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
      res_d       = res_new;
    end else begin
      out_valid_d = res_ready_i ? 1'b0 : out_valid_q;
      res_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtr_pkg::ST_WAIT;
      phase_q     <= rtr_pkg::PH_IDLE;
      exp_q       <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      exp_q       <= exp_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    match_q <= match_d;
    res_q   <= res_d;
    if (slot_wr) begin
      slot_seq_q[free_idx]  <= cur_q.seq;
      slot_size_q[free_idx] <= cur_q.size;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;

endmodule

// File: hw/rtl/reliable_transfer_receiver.sv
// Top level of the reliable transfer receiver: ports, configuration and wiring.
//
// Each request on the s_axis channel is one received packet header (SYN and
// FIN flags in tuser; sequence number, acknowledgement number and payload
// size in tdata). The m_axis channel returns the commands it causes: header
// sends, payload deliveries and store commands, with tlast on the final one
// of each request. Some requests (handshake ACK, final ACK, data while idle)
// cause none. The APB port holds the server initial sequence number.
// A request passes an input register and a two-entry queue, then the back
// end works on one request at a time: it takes the request in its wait
// state and classifies it in its dispatch state, sends each result in turn,
// and drains the slots in a loop of a compare state, then a pick state.
// Reset returns the block to the idle phase, expected sequence zero and all
// slots free; the initial sequence register returns to 7706.
// When the receiver stalls m_axis, the finished result waits in the output
// register while new requests still fill the input register and queue.
module reliable_transfer_receiver #(
  parameter int unsigned BUFFER_SLOTS = 8,
  parameter int unsigned MAX_PAYLOAD  = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // s_axis_tdata: seq_num[14:0], ack_num[29:15], data_size[39:30]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,
  // s_axis_tuser: syn_flag[0], fin_flag[1]
  input  logic [1:0]                 s_axis_tuser,
  // m_axis_tdata: out_ack_bit[0], out_syn_bit[1], out_fin_bit[2], out_seq[17:3],
  // out_ack[32:18], from_buffer[33], slot[36:34], deliver_seq[51:37],
  // deliver_size[61:52], zero fill[63:62]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [63:0]                m_axis_tdata,
  // m_axis_tuser: kind[1:0]
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [rtr_pkg::SEQ_W-1:0] init_q, init_d;
  logic [rtr_pkg::SEQ_W-1:0] init_mod, hs_ack;
  logic [0:0]                reg_idx;
  logic                      cfg_wr;

  rtr_pkg::item_t   front_item, fifo_item;
  logic             front_valid, fifo_ready, fifo_valid, back_ready;
  rtr_pkg::result_t res;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    init_d = init_q;
    if (cfg_wr && reg_idx == rtr_pkg::REG_INIT_SEQ) begin
      init_d = pwdata[rtr_pkg::SEQ_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      rtr_pkg::REG_INIT_SEQ: prdata = {17'd0, init_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= rtr_pkg::InitSeqReset;
    end else begin
      init_q <= init_d;
    end
  end

  // Reduce the initial sequence and form the expected handshake ACK
  assign init_mod = rtr_pkg::seq_wrap({1'b0, init_q});
  assign hs_ack   = rtr_pkg::seq_wrap({1'b0, init_mod} + 16'd1);

  rtr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .syn_i        (s_axis_tuser[0]),
    .fin_i        (s_axis_tuser[1]),
    .seq_i        (s_axis_tdata[14:0]),
    .ack_i        (s_axis_tdata[29:15]),
    .size_i       (s_axis_tdata[39:30]),
    .hs_ack_i     (hs_ack),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (fifo_ready)
  );

  rtr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .ready_o (fifo_ready),
    .pop_i   (back_ready),
    .data_o  (fifo_item),
    .valid_o (fifo_valid)
  );

  rtr_back #(
    .BUFFER_SLOTS (BUFFER_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (fifo_item),
    .item_valid_i (fifo_valid),
    .item_ready_o (back_ready),
    .init_seq_i   (init_mod),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  // Pack the result
  assign m_axis_tdata = {2'b00, res.dsize, res.dseq, res.slot, res.from_buffer,
                         res.ack, res.seq, res.fin_bit, res.syn_bit, res.ack_bit};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
